// ----- hw/rtl/circular_deque_core_defines.svh -----
// Assertion macros shared by the deque RTL
`ifndef CIRCULAR_DEQUE_CORE_DEFINES_SVH
`define CIRCULAR_DEQUE_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted
`define CDQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted
`define CDQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cdq_pkg.sv -----
// Types and constants for the circular deque
package cdq_pkg;

    // Element word
    typedef logic signed [31:0] t_word;

    // Command codes
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_PUSH_FRONT = 2'd0;
    localparam t_cmd CMD_PUSH_REAR  = 2'd1;
    localparam t_cmd CMD_POP_FRONT  = 2'd2;
    localparam t_cmd CMD_POP_REAR   = 2'd3;

    // Status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // Capacity register and entry count
    localparam int CNT_W = 5;
    typedef logic [CNT_W-1:0] t_cnt;
    localparam int   CAP_MAX   = 31;
    localparam t_cnt CAP_RESET = 5'd16;

    // Register map (index taken from paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    // Control broadcast to every cell
    typedef struct packed {
        logic  clear;
        logic  en;
        t_cmd  cmd;
        t_word push_value;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/circular_deque_core.sv -----
// Circular deque top level: command port, APB register, cell chain
//
// Usage:
//   Command channel: drive i_command and i_value with start high; the
//   transaction is taken at a rising edge where start is high and busy low.
//   busy stays low, so one command may be issued every cycle.
//   Result channel: o_result_valid is high for exactly one cycle, in the cycle
//   after the command is taken, with o_status, o_entry_count and
//   o_removed_value. The receiver cannot hold results off; it must sample
//   them in that cycle.
//   Throughput is 1 command per cycle: the elements sit in a chain of cells,
//   one per slot, and every cell shifts or loads in the same cycle, so a push
//   or pop at either end is done in a single register update.
//   APB port: one register, capacity_in_use at byte address 0. Writing it
//   empties the deque. pready is tied high.
//   Reset (synchronous, active low) empties the deque and sets the
//   capacity to 16. Slot contents are undefined until written.
//   A capacity of 0 acts as 1; one above STORE_DEPTH acts as STORE_DEPTH.
`include "circular_deque_core_defines.svh"

module circular_deque_core #(
    parameter int STORE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  cdq_pkg::t_cmd      i_command,
    input  cdq_pkg::t_word     i_value,
    // result channel
    output logic               o_result_valid,
    output cdq_pkg::t_status   o_status,
    output cdq_pkg::t_cnt      o_entry_count,
    output cdq_pkg::t_word     o_removed_value,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cdq_pkg::*;

    // Slots beyond what the 5-bit capacity can reach are never built
    localparam int   NCELL    = (STORE_DEPTH < CAP_MAX) ? STORE_DEPTH : CAP_MAX;
    localparam t_cnt CELL_CNT = t_cnt'(NCELL);

    t_cnt      r_cap;
    t_cnt      r_count;
    t_cnt      n_count;
    t_cnt      w_act_cap;
    logic      r_result_valid;
    t_status   r_status;
    t_status   n_status;
    t_word     r_removed;
    t_word     n_removed;
    t_word     w_rear_data;
    logic      w_accept;
    logic      w_cfg_wr;
    logic      w_is_push;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;

    t_word             w_data  [NCELL];
    logic [NCELL-1:0]  w_valid;
    logic [NCELL-1:0]  w_rear;

    // Handshakes
    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_accept = start & ~busy;
    assign w_cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_CAPACITY);

    // Register read
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = {{(32-CNT_W){1'b0}}, r_cap};
        end
    end

    // Capacity in effect, clamped to 1..NCELL
    always_comb begin
        if (r_cap == '0) begin
            w_act_cap = t_cnt'(1);
        end else if (r_cap > CELL_CNT) begin
            w_act_cap = CELL_CNT;
        end else begin
            w_act_cap = r_cap;
        end
    end

    // Command decode
    assign w_is_push = (i_command == CMD_PUSH_FRONT) || (i_command == CMD_PUSH_REAR);
    assign w_full    = w_is_push && (r_count >= w_act_cap);
    assign w_empty   = !w_is_push && (r_count == '0);

    // Broadcast control to the chain
    always_comb begin
        w_ctl.clear      = w_cfg_wr;
        w_ctl.en         = w_accept & ~w_full & ~w_empty;
        w_ctl.cmd        = i_command;
        w_ctl.push_value = i_value;
    end

    // Cell chain: cell 0 holds the front, the last valid cell the rear
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        t_word w_left_data;
        logic  w_left_valid;
        t_word w_right_data;
        logic  w_right_valid;

        if (k == 0) begin : g_first
            assign w_left_data  = i_value;
            assign w_left_valid = 1'b1;
        end else begin : g_mid
            assign w_left_data  = w_data[k-1];
            assign w_left_valid = w_valid[k-1];
        end

        if (k == NCELL-1) begin : g_last
            assign w_right_data  = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_data  = w_data[k+1];
            assign w_right_valid = w_valid[k+1];
        end

        cdq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_left_data   (w_left_data),
            .i_left_valid  (w_left_valid),
            .i_right_data  (w_right_data),
            .i_right_valid (w_right_valid),
            .o_data        (w_data[k]),
            .o_valid       (w_valid[k]),
            .o_rear        (w_rear[k])
        );
    end

    // Rear element: only one cell flags itself as the rear
    always_comb begin
        w_rear_data = '0;
        for (int k = 0; k < NCELL; k++) begin
            w_rear_data = w_rear_data | (w_rear[k] ? w_data[k] : t_word'(0));
        end
    end

    // Result and next count
    always_comb begin
        n_count   = r_count;
        n_status  = ST_OK;
        n_removed = '0;
        if (w_full) begin
            n_status = ST_FULL;
        end else if (w_empty) begin
            n_status = ST_EMPTY;
        end else begin
            case (i_command)
                CMD_PUSH_FRONT,
                CMD_PUSH_REAR: begin
                    n_count = r_count + t_cnt'(1);
                end
                CMD_POP_FRONT: begin
                    n_count   = r_count - t_cnt'(1);
                    n_removed = w_data[0];
                end
                CMD_POP_REAR: begin
                    n_count   = r_count - t_cnt'(1);
                    n_removed = w_rear_data;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap          <= CAP_RESET;
            r_count        <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= w_accept;
            if (w_cfg_wr) begin
                r_cap   <= pwdata[CNT_W-1:0];
                r_count <= '0;
            end else if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_result_valid  = r_result_valid;
    assign o_status        = r_status;
    assign o_entry_count   = r_count;
    assign o_removed_value = r_removed;

    // Checks
    `CDQ_ASSERT_IMP(a_count_matches_cells, i_clk, i_rst_n, 1'b1,
        r_count == t_cnt'($countones(w_valid)), "entry count disagrees with cell valid flags")
    `CDQ_ASSERT_IMP(a_cells_contiguous, i_clk, i_rst_n, 1'b1,
        (w_valid & (w_valid + 1'b1)) == '0, "valid cells do not form a run from the front")
    `CDQ_ASSERT_IMP(a_count_within_cap, i_clk, i_rst_n, 1'b1,
        r_count <= w_act_cap, "entry count exceeds capacity in effect")
    `CDQ_ASSERT_NXT(a_refused_push_holds, i_clk, i_rst_n, w_accept && w_full && !w_cfg_wr,
        o_result_valid && (o_status == ST_FULL) && (r_count == $past(r_count)),
        "refused push changed the deque or lost its result")

endmodule

// ----- hw/rtl/cdq_cell.sv -----
// One slot of the deque chain: holds an element and its valid flag
module cdq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cdq_pkg::t_cell_ctl i_ctl,
    input  cdq_pkg::t_word    i_left_data,
    input  logic              i_left_valid,
    input  cdq_pkg::t_word    i_right_data,
    input  logic              i_right_valid,
    output cdq_pkg::t_word    o_data,
    output logic              o_valid,
    output logic              o_rear
);
    import cdq_pkg::*;

    t_word r_data;
    t_word n_data;
    logic  r_valid;
    logic  n_valid;

    // Next slot contents: clear, shift towards the rear, shift towards the front,
    // or take/drop at the rear boundary
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.en) begin
            case (i_ctl.cmd)
                CMD_PUSH_FRONT: begin
                    n_data  = i_left_data;
                    n_valid = i_left_valid;
                end
                CMD_PUSH_REAR: begin
                    if (!r_valid && i_left_valid) begin
                        n_data  = i_ctl.push_value;
                        n_valid = 1'b1;
                    end
                end
                CMD_POP_FRONT: begin
                    n_data  = i_right_data;
                    n_valid = i_right_valid;
                end
                CMD_POP_REAR: begin
                    if (r_valid && !i_right_valid) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    // Valid flag is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Element payload, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_rear  = r_valid & ~i_right_valid;

endmodule
